### rtl/ffc_pkg.sv
// Shared types and constants for the fixed-length frame checker.
package ffc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned FIELDS_W    = 56;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned STORE_DEPTH = 11;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] FRAME_BYTES = 4'd12;
  localparam logic [POS_W-1:0] LAST_POS    = 4'd11;
  localparam logic [POS_W-1:0] SUM_SPAN    = 4'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'd13;
  localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_ERR  = 2'd1,
    ST_TAIL_ERR = 2'd2,
    ST_SUM_ERR  = 2'd3
  } status_t;

  // Expected header and tail bytes
  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] tail_first;
    logic [BYTE_W-1:0] tail_second;
  } cfg_t;

  // One checked frame on its way to the result stage
  typedef struct packed {
    status_t             status;
    logic [FIELDS_W-1:0] fields;  // bytes 2..8, byte 2 on top
  } chk_t;

endpackage

### rtl/ffc_assembler.sv
// Frame assembly: byte position, running sum, frame store and frame checks.
module ffc_assembler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_take,
  input  logic [ffc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        frame_end,
  input  ffc_pkg::cfg_t               cfg,
  input  logic                        chk_take,
  output logic                        chk_valid,
  output ffc_pkg::chk_t               chk
);

  logic [ffc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       too_long_r, too_long_nxt;
  logic [ffc_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [ffc_pkg::BYTE_W-1:0] bytes_r [ffc_pkg::STORE_DEPTH];
  logic                       chk_valid_r;
  ffc_pkg::chk_t              chk_r, chk_nxt;
  logic                       fire;

  // Frame of exactly twelve bytes ends with this byte
  assign fire = byte_take & frame_end & ~too_long_r & (pos_r == ffc_pkg::LAST_POS);

  always_comb begin
    pos_nxt      = pos_r;
    too_long_nxt = too_long_r;
    sum_nxt      = sum_r;
    if (byte_take) begin
      if (pos_r < ffc_pkg::FRAME_BYTES) begin
        if (pos_r < ffc_pkg::SUM_SPAN) begin
          sum_nxt = sum_r + rx_byte;
        end
        pos_nxt = pos_r + 4'd1;
      end else begin
        too_long_nxt = 1'b1;
      end
      if (frame_end) begin
        pos_nxt      = '0;
        too_long_nxt = 1'b0;
        sum_nxt      = '0;
      end
    end
  end

  // Checks in priority order; byte 11 is the byte arriving now
  always_comb begin
    chk_nxt.fields = {bytes_r[2], bytes_r[3], bytes_r[4], bytes_r[5],
                      bytes_r[6], bytes_r[7], bytes_r[8]};
    priority if (bytes_r[0] != cfg.header_first || bytes_r[1] != cfg.header_second) begin
      chk_nxt.status = ffc_pkg::ST_HDR_ERR;
    end else if (bytes_r[10] != cfg.tail_first || rx_byte != cfg.tail_second) begin
      chk_nxt.status = ffc_pkg::ST_TAIL_ERR;
    end else if (sum_r != bytes_r[9]) begin
      chk_nxt.status = ffc_pkg::ST_SUM_ERR;
    end else begin
      chk_nxt.status = ffc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      too_long_r  <= 1'b0;
      sum_r       <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      too_long_r <= too_long_nxt;
      sum_r      <= sum_nxt;
      if (fire) begin
        chk_valid_r <= 1'b1;
      end else if (chk_take) begin
        chk_valid_r <= 1'b0;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (byte_take && pos_r < ffc_pkg::LAST_POS) begin
      bytes_r[pos_r] <= rx_byte;
    end
    if (fire) begin
      chk_r <= chk_nxt;
    end
  end

  assign chk_valid = chk_valid_r;
  assign chk       = chk_r;

endmodule

### rtl/ffc_result.sv
// Result stage: decoded fields, frame counters and the output register.
module ffc_result (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          chk_valid,
  input  ffc_pkg::chk_t                 chk,
  input  logic                          out_stall,
  output logic                          res_free,
  output logic                          out_valid,
  output ffc_pkg::status_t              status,
  output logic                          have_frame,
  output logic [ffc_pkg::FIELDS_W-1:0]  fields,
  output logic [ffc_pkg::COUNT_W-1:0]   good_count,
  output logic [ffc_pkg::COUNT_W-1:0]   err_total,
  output logic [ffc_pkg::COUNT_W-1:0]   sum_error_count
);

  logic                         out_valid_r;
  ffc_pkg::status_t             status_r;
  logic                         good_seen_r;
  logic [ffc_pkg::FIELDS_W-1:0] fields_r;
  logic [ffc_pkg::COUNT_W-1:0]  good_r, err_r, sum_err_r;
  logic                         take;

  assign res_free = ~out_valid_r | ~out_stall;
  assign take     = chk_valid & res_free;

  // The state registers double as the output register: they only change
  // when the previous result has been transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= ffc_pkg::ST_OK;
      good_seen_r <= 1'b0;
      fields_r    <= '0;
      good_r      <= '0;
      err_r       <= '0;
      sum_err_r   <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        status_r    <= chk.status;
        if (chk.status == ffc_pkg::ST_OK) begin
          good_seen_r <= 1'b1;
          fields_r    <= chk.fields;
          good_r      <= good_r + 32'd1;
        end else begin
          err_r <= err_r + 32'd1;
          if (chk.status == ffc_pkg::ST_SUM_ERR) begin
            sum_err_r <= sum_err_r + 32'd1;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign status          = status_r;
  assign have_frame      = good_seen_r;
  assign fields          = fields_r;
  assign good_count      = good_r;
  assign err_total       = err_r;
  assign sum_error_count = sum_err_r;

endmodule

### rtl/fixed_frame_checker_core.sv
// Top level of the fixed-length frame checker with 8-bit sum checksum.
//
// Bytes of a frame arrive one per transfer on the in_ channel, with
// in_frame_end on the last byte. A frame of exactly 12 bytes yields one
// result transfer on the out_ channel; any other length yields none and
// leaves the counters alone. Checks run header (bytes 0,1), tail (bytes
// 10,11), then checksum (byte 9 against the 8-bit sum of bytes 0..8).
// The decoded fields always show the last good frame. Throughput is one
// byte per clock while in_stall is low: byte counter, running sum and
// compares sit between the input and a one-entry check register, and
// the counters update in the result register behind it, so a result
// passes the check register, then the result register. in_stall rises
// only when a checked frame waits behind a result the sink has not taken.
module fixed_frame_checker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_wr_en,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffc_pkg::BYTE_W-1:0]         cfg_data,
  // Byte input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ffc_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic                               in_frame_end,
  // Result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_have_frame,
  output logic [7:0]                         out_mode_value,
  output logic [7:0]                         out_id_value,
  output logic signed [15:0]                 out_x_value,
  output logic signed [15:0]                 out_y_value,
  output logic [7:0]                         out_reserved_value,
  output logic [ffc_pkg::COUNT_W-1:0]        out_good_count,
  output logic [ffc_pkg::COUNT_W-1:0]        out_error_count,
  output logic [ffc_pkg::COUNT_W-1:0]        out_sum_error_count
);

  ffc_pkg::cfg_t                cfg_r;
  logic                         byte_take;
  logic                         chk_valid;
  logic                         chk_take;
  logic                         res_free;
  ffc_pkg::chk_t                chk;
  ffc_pkg::status_t             status;
  logic [ffc_pkg::FIELDS_W-1:0] fields;

  // Config registers: the user must write them only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= ffc_pkg::HEADER_FIRST_RST;
      cfg_r.header_second <= ffc_pkg::HEADER_SECOND_RST;
      cfg_r.tail_first    <= ffc_pkg::TAIL_FIRST_RST;
      cfg_r.tail_second   <= ffc_pkg::TAIL_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ffc_pkg::REG_HEADER_FIRST:  cfg_r.header_first  <= cfg_data;
        ffc_pkg::REG_HEADER_SECOND: cfg_r.header_second <= cfg_data;
        ffc_pkg::REG_TAIL_FIRST:    cfg_r.tail_first    <= cfg_data;
        ffc_pkg::REG_TAIL_SECOND:   cfg_r.tail_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall only while the check slot is full and cannot move on
  assign chk_take  = chk_valid & res_free;
  assign in_stall  = chk_valid & ~res_free;
  assign byte_take = in_valid & ~in_stall;

  ffc_assembler u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .cfg       (cfg_r),
    .chk_take  (chk_take),
    .chk_valid (chk_valid),
    .chk       (chk)
  );

  ffc_result u_res (
    .clk             (clk),
    .rst_n           (rst_n),
    .chk_valid       (chk_valid),
    .chk             (chk),
    .out_stall       (out_stall),
    .res_free        (res_free),
    .out_valid       (out_valid),
    .status          (status),
    .have_frame      (out_have_frame),
    .fields          (fields),
    .good_count      (out_good_count),
    .err_total       (out_error_count),
    .sum_error_count (out_sum_error_count)
  );

  // Unpack bytes 2..8: mode, id, X (big-endian), Y (big-endian), reserved
  assign out_status         = status;
  assign out_mode_value     = fields[55:48];
  assign out_id_value       = fields[47:40];
  assign out_x_value        = $signed(fields[39:24]);
  assign out_y_value        = $signed(fields[23:8]);
  assign out_reserved_value = fields[7:0];

endmodule
